// ===== src/pdd_pkg.sv =====
`timescale 1ns / 1ps
package pdd_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned TIMERS  = 3;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned LEN_W   = $clog2(ENTRIES + 1);
  localparam int unsigned TMR_W   = $clog2(TIMERS + 1);
  localparam int unsigned PER_W   = 16;
  localparam int unsigned CFG_W   = 2;

  // Operation codes
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_ARM    = 3'd2;
  localparam logic [2:0] OP_DISARM = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // Register indexes
  localparam logic [CFG_W-1:0] CFG_FAST = 2'd0;
  localparam logic [CFG_W-1:0] CFG_MID  = 2'd1;
  localparam logic [CFG_W-1:0] CFG_SLOW = 2'd2;

  // Result kinds
  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  timer_sel;
    logic [15:0] callback_id;
    logic [15:0] context_tag;
    logic [7:0]  priority_req;
    logic        single_fire;
    logic [3:0]  handle;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        accepted;
    logic [3:0]  entry_handle;
    logic [1:0]  fired_timer;
    logic [15:0] context_value;
    logic        is_last;
  } out_item_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } head_t;

endpackage

// ===== src/pdd_front.sv =====
`timescale 1ns / 1ps
// Two-deep command queue between the port and the execution engine
module pdd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pdd_pkg::in_item_t  in_i,
  output logic               busy_o,
  output pdd_pkg::head_t     head_o,
  input  logic               pop_i
);

  pdd_pkg::in_item_t mem_q [2];
  logic              wr_q, wr_d, rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // payload beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_i;
    end
  end

endmodule

// ===== src/pdd_back.sv =====
`timescale 1ns / 1ps
// Execution engine: entry pool, priority list walks and timers
module pdd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdd_pkg::head_t                head_i,
  output logic                          pop_o,
  input  logic                          cfg_we_i,
  input  logic [pdd_pkg::CFG_W-1:0]     cfg_idx_i,
  input  logic [pdd_pkg::PER_W-1:0]     cfg_data_i,
  output logic                          res_valid_o,
  output pdd_pkg::out_item_t            res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;

  localparam int unsigned E  = pdd_pkg::ENTRIES;
  localparam int unsigned T  = pdd_pkg::TIMERS;
  localparam int unsigned IW = pdd_pkg::IDX_W;
  localparam int unsigned LW = pdd_pkg::LEN_W;
  localparam int unsigned TW = pdd_pkg::TMR_W;
  localparam int unsigned PW = pdd_pkg::PER_W;

  logic [2:0]  state_q, state_d;
  logic [LW-1:0] idx_q, idx_d, len_q, len_d;
  logic [TW-1:0] tmr_q, tmr_d;
  logic [T-1:0]  fire_q, fire_d;
  pdd_pkg::in_item_t cmd_q, cmd_d;

  logic [E-1:0] valid_q, valid_d, armed_q, armed_d;
  logic [IW-1:0] order_q [E];
  logic [IW-1:0] order_d [E];
  logic [1:0]  tim_q  [E];
  logic [1:0]  tim_d  [E];
  logic [7:0]  prio_q [E];
  logic [7:0]  prio_d [E];
  logic [15:0] cb_q   [E];
  logic [15:0] cb_d   [E];
  logic [15:0] ctx_q  [E];
  logic [15:0] ctx_d  [E];
  logic [E-1:0] once_q, once_d;

  logic [PW-1:0] tick_q [T];
  logic [PW-1:0] tick_d [T];
  logic [LW-1:0] atot_q [T];
  logic [LW-1:0] atot_d [T];
  logic [PW-1:0] per_q  [T];

  logic               res_v_q, res_v_d, pend_v_q, pend_v_d;
  pdd_pkg::out_item_t res_q, res_d, pend_q, pend_d;

  logic [IW-1:0] slot, cur;
  logic          slot_ok;
  logic [PW:0]   cnt_nx;
  logic [PW-1:0] per_eff;
  logic [1:0]    ttim;
  logic [IW-1:0] pos;

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // lowest free handle
  always_comb begin
    slot    = '0;
    slot_ok = 1'b0;
    for (int i = E - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        slot    = IW'(i);
        slot_ok = 1'b1;
      end
    end
  end

  assign cur = order_q[idx_q[IW-1:0]];
  assign pos = idx_q[IW-1:0];

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    len_d    = len_q;
    tmr_d    = tmr_q;
    fire_d   = fire_q;
    cmd_d    = cmd_q;
    valid_d  = valid_q;
    armed_d  = armed_q;
    once_d   = once_q;
    order_d  = order_q;
    tim_d    = tim_q;
    prio_d   = prio_q;
    cb_d     = cb_q;
    ctx_d    = ctx_q;
    tick_d   = tick_q;
    atot_d   = atot_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    pop_o    = 1'b0;
    cnt_nx   = '0;
    per_eff  = '0;
    ttim     = '0;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cmd_d = head_i.item;
          idx_d = '0;
          case (head_i.item.operation)
            pdd_pkg::OP_ADD: begin
              if (head_i.item.timer_sel < 2'(T) && slot_ok) begin
                state_d = S_ADD;
              end else begin
                res_v_d = 1'b1;
                res_d   = '{result_kind: pdd_pkg::KIND_ADD, accepted: 1'b0,
                            entry_handle: '0, fired_timer: '0,
                            context_value: '0, is_last: 1'b1};
              end
            end
            pdd_pkg::OP_REMOVE: begin
              if (head_i.item.timer_sel < 2'(T)) state_d = S_REM;
            end
            pdd_pkg::OP_ARM: begin
              if (valid_q[head_i.item.handle[IW-1:0]] &&
                  !armed_q[head_i.item.handle[IW-1:0]] &&
                  tim_q[head_i.item.handle[IW-1:0]] < 2'(T)) begin
                ttim = tim_q[head_i.item.handle[IW-1:0]];
                armed_d[head_i.item.handle[IW-1:0]] = 1'b1;
                atot_d[ttim] = atot_q[ttim] + 1'b1;
              end
            end
            pdd_pkg::OP_DISARM: begin
              if (valid_q[head_i.item.handle[IW-1:0]] &&
                  armed_q[head_i.item.handle[IW-1:0]]) begin
                ttim = tim_q[head_i.item.handle[IW-1:0]];
                armed_d[head_i.item.handle[IW-1:0]] = 1'b0;
                if (atot_q[ttim] != '0) atot_d[ttim] = atot_q[ttim] - 1'b1;
                if (atot_q[ttim] <= LW'(1)) tick_d[ttim] = '0;
              end
            end
            pdd_pkg::OP_TICK: begin
              // advance every timer, note which ones fire
              for (int t = 0; t < T; t++) begin
                fire_d[t] = 1'b0;
                per_eff   = (per_q[t] == '0) ? PW'(1) : per_q[t];
                cnt_nx    = {1'b0, tick_q[t]} + 1'b1;
                if (atot_q[t] == '0) begin
                  tick_d[t] = '0;
                end else if (cnt_nx >= {1'b0, per_eff}) begin
                  tick_d[t] = '0;
                  fire_d[t] = 1'b1;
                end else begin
                  tick_d[t] = cnt_nx[PW-1:0];
                end
              end
              tmr_d   = '0;
              state_d = S_SEL;
            end
            default: ;
          endcase
        end
      end

      // find insert place: after all entries of equal or higher priority
      S_ADD: begin
        if (idx_q == len_q || prio_q[cur] < cmd_q.priority_req) begin
          for (int j = 1; j < E; j++) begin
            if (IW'(j) > pos) order_d[j] = order_q[j-1];
          end
          order_d[pos]  = slot;
          valid_d[slot] = 1'b1;
          armed_d[slot] = 1'b0;
          once_d[slot]  = cmd_q.single_fire;
          tim_d[slot]   = cmd_q.timer_sel;
          prio_d[slot]  = cmd_q.priority_req;
          cb_d[slot]    = cmd_q.callback_id;
          ctx_d[slot]   = cmd_q.context_tag;
          len_d         = len_q + 1'b1;
          res_v_d       = 1'b1;
          res_d = '{result_kind: pdd_pkg::KIND_ADD, accepted: 1'b1,
                    entry_handle: 4'(slot), fired_timer: '0,
                    context_value: '0, is_last: 1'b1};
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // first list entry with matching timer and callback goes away
      S_REM: begin
        if (idx_q == len_q) begin
          state_d = S_IDLE;
        end else if (tim_q[cur] == cmd_q.timer_sel &&
                     cb_q[cur] == cmd_q.callback_id) begin
          ttim = tim_q[cur];
          if (armed_q[cur]) begin
            armed_d[cur] = 1'b0;
            if (atot_q[ttim] != '0) atot_d[ttim] = atot_q[ttim] - 1'b1;
            if (atot_q[ttim] <= LW'(1)) tick_d[ttim] = '0;
          end
          valid_d[cur] = 1'b0;
          for (int j = 0; j < E - 1; j++) begin
            if (IW'(j) >= pos) order_d[j] = order_q[j+1];
          end
          len_d   = len_q - 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // next firing timer in timer order
      S_SEL: begin
        idx_d = '0;
        if (tmr_q == TW'(T)) begin
          state_d = S_END;
        end else if (fire_q[tmr_q[1:0]]) begin
          state_d = S_WALK;
        end else begin
          tmr_d = tmr_q + 1'b1;
        end
      end

      // dispatch armed entries of this timer, disarm the one-shot ones
      S_WALK: begin
        if (idx_q == len_q) begin
          tmr_d   = tmr_q + 1'b1;
          state_d = S_SEL;
        end else begin
          idx_d = idx_q + 1'b1;
          ttim  = tmr_q[1:0];
          if (armed_q[cur] && tim_q[cur] == ttim) begin
            if (pend_v_q) begin
              res_v_d = 1'b1;
              res_d   = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d = '{result_kind: pdd_pkg::KIND_DISPATCH, accepted: 1'b0,
                       entry_handle: 4'(cur), fired_timer: ttim,
                       context_value: ctx_q[cur], is_last: 1'b0};
            if (once_q[cur]) begin
              armed_d[cur] = 1'b0;
              if (atot_q[ttim] != '0) atot_d[ttim] = atot_q[ttim] - 1'b1;
              if (atot_q[ttim] <= LW'(1)) tick_d[ttim] = '0;
            end
          end
        end
      end

      // flush the held dispatch as the last beat of this tick
      S_END: begin
        if (pend_v_q) begin
          res_v_d        = 1'b1;
          res_d          = pend_q;
          res_d.is_last  = 1'b1;
          pend_v_d       = 1'b0;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      len_q    <= '0;
      tmr_q    <= '0;
      fire_q   <= '0;
      valid_q  <= '0;
      armed_q  <= '0;
      res_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      for (int t = 0; t < T; t++) begin
        tick_q[t] <= '0;
        atot_q[t] <= '0;
      end
      per_q[0] <= PW'(10);
      if (T > 1) per_q[1] <= PW'(100);
      if (T > 2) per_q[2] <= PW'(200);
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      tmr_q    <= tmr_d;
      fire_q   <= fire_d;
      valid_q  <= valid_d;
      armed_q  <= armed_d;
      res_v_q  <= res_v_d;
      pend_v_q <= pend_v_d;
      tick_q   <= tick_d;
      atot_q   <= atot_d;
      // period registers
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pdd_pkg::CFG_FAST: per_q[0] <= cfg_data_i;
          pdd_pkg::CFG_MID:  if (T > 1) per_q[1] <= cfg_data_i;
          pdd_pkg::CFG_SLOW: if (T > 2) per_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    order_q <= order_d;
    tim_q   <= tim_d;
    prio_q  <= prio_d;
    cb_q    <= cb_d;
    ctx_q   <= ctx_d;
    once_q  <= once_d;
    res_q   <= res_d;
    pend_q  <= pend_d;
  end

endmodule

// ===== src/periodic_priority_dispatcher_top.sv =====
`timescale 1ns / 1ps
// Timer entry pool with priority-ordered dispatch. Commands enter a two-deep
// queue while busy is low; the engine behind it runs one command at a time.
// Arm and disarm finish as the command is taken, add and remove walk the priority
// list, and a tick walks the list once per firing timer. Results appear as
// single-cycle beats on res_valid_o and cannot be held off: the receiver must take
// every beat. is_last marks the final beat of each command; commands that give no
// result emit nothing.
module periodic_priority_dispatcher_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pdd_pkg::in_item_t         in_i,
  input  logic                      cfg_we_i,
  input  logic [pdd_pkg::CFG_W-1:0] cfg_idx_i,
  input  logic [pdd_pkg::PER_W-1:0] cfg_data_i,
  output logic                      res_valid_o,
  output pdd_pkg::out_item_t        res_o
);

  pdd_pkg::head_t head;
  logic           pop;

  pdd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .in_i    (in_i),
    .busy_o  (busy),
    .head_o  (head),
    .pop_i   (pop)
  );

  pdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
